// ===== rtl/core/ats_pkg.sv =====
// shared constants, types and helpers of the alphanumeric tokenizer and stemmer
`timescale 1ns / 1ps
package ats_pkg;

   localparam int TOKEN_BUFFER_SIZE = 64;
   localparam int CAPACITY          = TOKEN_BUFFER_SIZE - 1;
   localparam int IDX_W             = $clog2(CAPACITY);
   localparam int LEN_W             = $clog2(CAPACITY + 1);
   localparam int ADDR_W            = IDX_W + 1;
   localparam int MEM_DEPTH         = 2 ** ADDR_W;
   localparam int QUEUE_DEPTH       = 2;
   localparam int QPTR_W            = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W            = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] CHAR_I = 8'h69;
   localparam logic [7:0] CHAR_N = 8'h6E;
   localparam logic [7:0] CHAR_G = 8'h67;
   localparam logic [7:0] CHAR_E = 8'h65;
   localparam logic [7:0] CHAR_D = 8'h64;
   localparam logic [7:0] CHAR_S = 8'h73;

   // one buffer write from the front into the character store
   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [7:0]        data;
   } wr_port_type;

   // one finished token: its bank and its stemmed length
   typedef struct packed {
      logic             bank;
      logic [LEN_W-1:0] len;
   } desc_type;

   // back hands a bank back to the front
   typedef struct packed {
      logic valid;
      logic bank;
   } release_type;

   function automatic logic is_word_byte(input logic [7:0] c);
      return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
             (c >= 8'h61 && c <= 8'h7A);
   endfunction

   function automatic logic [7:0] fold_lower(input logic [7:0] c);
      return (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
   endfunction

endpackage

// ===== rtl/core/ats_front.sv =====
// front: takes text bytes, buffers word characters, stems and queues finished tokens
`timescale 1ns / 1ps
module ats_front
   import ats_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_text_byte,
   input  release_type rel,
   output wr_port_type wr,
   output logic        push,
   output desc_type    push_desc
);

   logic             wbank_ff, wbank_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [1:0]       busy_ff, busy_in;
   logic [7:0]       tail1_ff, tail1_in;
   logic [7:0]       tail2_ff, tail2_in;
   logic [7:0]       tail3_ff, tail3_in;
   logic             accept, word, store;
   logic [LEN_W-1:0] stem_len;

   assign req_stall = busy_ff[wbank_ff];
   assign accept    = req_valid && !req_stall;
   assign word      = is_word_byte(req_text_byte);
   assign store     = accept && word && (len_ff < LEN_W'(CAPACITY));

   always_comb begin
      priority if (len_ff > LEN_W'(5) && tail3_ff == CHAR_I && tail2_ff == CHAR_N &&
                   tail1_ff == CHAR_G) begin
         stem_len = len_ff - LEN_W'(3);
      end else if (len_ff > LEN_W'(4) && tail2_ff == CHAR_E && tail1_ff == CHAR_D) begin
         stem_len = len_ff - LEN_W'(2);
      end else if (len_ff > LEN_W'(4) && tail2_ff == CHAR_E && tail1_ff == CHAR_S) begin
         stem_len = len_ff - LEN_W'(2);
      end else if (len_ff > LEN_W'(3) && tail1_ff == CHAR_S) begin
         stem_len = len_ff - LEN_W'(1);
      end else begin
         stem_len = len_ff;
      end
   end

   assign wr.en          = store;
   assign wr.addr        = {wbank_ff, len_ff[IDX_W-1:0]};
   assign wr.data        = fold_lower(req_text_byte);
   assign push           = accept && !store && (len_ff != '0);
   assign push_desc.bank = wbank_ff;
   assign push_desc.len  = stem_len;

   always_comb begin
      wbank_in = wbank_ff;
      len_in   = len_ff;
      busy_in  = busy_ff;
      tail1_in = tail1_ff;
      tail2_in = tail2_ff;
      tail3_in = tail3_ff;
      if (rel.valid) begin
         busy_in[rel.bank] = 1'b0;
      end
      if (store) begin
         len_in   = len_ff + LEN_W'(1);
         tail1_in = wr.data;
         tail2_in = tail1_ff;
         tail3_in = tail2_ff;
      end else if (push) begin
         busy_in[wbank_ff] = 1'b1;
         wbank_in          = !wbank_ff;
         len_in            = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wbank_ff <= 1'b0;
         len_ff   <= '0;
         busy_ff  <= '0;
      end else begin
         wbank_ff <= wbank_in;
         len_ff   <= len_in;
         busy_ff  <= busy_in;
      end
      tail1_ff <= tail1_in;
      tail2_ff <= tail2_in;
      tail3_ff <= tail3_in;
   end

endmodule

// ===== rtl/core/ats_queue.sv =====
// short token descriptor queue between front and back
`timescale 1ns / 1ps
module ats_queue
   import ats_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  desc_type push_desc,
   input  logic     pop,
   output logic     empty,
   output desc_type head
);

   desc_type          slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wptr_ff, wptr_in;
   logic [QPTR_W-1:0] rptr_ff, rptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign empty = (count_ff == '0);
   assign head  = slot_ff[rptr_ff];

   always_comb begin
      wptr_in  = wptr_ff;
      rptr_in  = rptr_ff;
      count_in = count_ff;
      if (push) begin
         wptr_in = (wptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_ff + QPTR_W'(1);
      end
      if (pop) begin
         rptr_in = (rptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_ff + QPTR_W'(1);
      end
      unique case ({push, pop})
         2'b10:   count_in = count_ff + QCNT_W'(1);
         2'b01:   count_in = count_ff - QCNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
      if (push) begin
         slot_ff[wptr_ff] <= push_desc;
      end
   end

endmodule

// ===== rtl/core/ats_back.sv =====
// back: character store and the drain that emits stemmed tokens
`timescale 1ns / 1ps
module ats_back
   import ats_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  wr_port_type wr,
   input  logic        q_empty,
   input  desc_type    q_head,
   output logic        pop,
   output release_type rel,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_token_char,
   output logic        rsp_token_last
);

   logic [7:0]       mem [MEM_DEPTH];
   logic             active_ff, active_in;
   logic             bank_ff, bank_in;
   logic [IDX_W-1:0] k_ff, k_in;
   logic [LEN_W-1:0] n_ff, n_in;
   logic             out_valid_ff, out_valid_in;
   logic [7:0]       out_char_ff;
   logic             out_last_ff;
   logic             rd_en, rd_last;

   assign rd_en   = active_ff && (!out_valid_ff || !rsp_stall);
   assign rd_last = (LEN_W'(k_ff) + LEN_W'(1)) == n_ff;
   assign pop     = !active_ff && !q_empty;

   assign rel.valid = rd_en && rd_last;
   assign rel.bank  = bank_ff;

   assign rsp_valid      = out_valid_ff;
   assign rsp_token_char = out_char_ff;
   assign rsp_token_last = out_last_ff;

   always_comb begin
      active_in    = active_ff;
      bank_in      = bank_ff;
      k_in         = k_ff;
      n_in         = n_ff;
      out_valid_in = out_valid_ff;
      if (pop) begin
         active_in = 1'b1;
         bank_in   = q_head.bank;
         n_in      = q_head.len;
         k_in      = '0;
      end else if (rd_en) begin
         k_in = k_ff + IDX_W'(1);
         if (rd_last) begin
            active_in = 1'b0;
         end
      end
      if (rd_en) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      if (rd_en) begin
         out_char_ff <= mem[{bank_ff, k_ff}];
         out_last_ff <= rd_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         out_valid_ff <= out_valid_in;
      end
      bank_ff <= bank_in;
      k_ff    <= k_in;
      n_ff    <= n_in;
   end

endmodule

// ===== rtl/core/alnum_tokenizer_suffix_stemmer_unit.sv =====
// top level of the alphanumeric tokenizer with suffix stemmer
// usage:
//  - req channel: one text byte per transfer; letters and digits extend the
//    current token (folded to lower case), any other byte ends it
//  - rsp channel: the stemmed token, one character per transfer, with
//    rsp_token_last on its final character; empty tokens give nothing
//  - a letter or digit arriving with 63 characters buffered ends the token
//    and is itself dropped
//  - a word byte is written to the store as it is taken; at a token's end the
//    front queues its descriptor, then the back loads it and reads the characters
//    in order, paced by the single read port of the character store
//  - the first character goes out through the queue, the back and its output register
//  - two buffer banks: the front fills one while the back drains the other;
//    req_stall rises only when the front's next bank is still draining
//  - rsp_stall holds the output register; the drain waits, the front runs on
//  - reset empties the queue and frees both banks; the store needs no clearing
`timescale 1ns / 1ps
module alnum_tokenizer_suffix_stemmer_unit
   import ats_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_text_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_token_char,
   output logic       rsp_token_last
);

   // front to store and queue
   wr_port_type wr;
   logic        push;
   desc_type    push_desc;
   // queue to back
   logic        pop;
   logic        q_empty;
   desc_type    q_head;
   // back hands drained banks back
   release_type rel;

   ats_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_text_byte (req_text_byte),
      .rel           (rel),
      .wr            (wr),
      .push          (push),
      .push_desc     (push_desc)
   );

   // at most two tokens outstanding, one per bank, so two slots never overflow
   ats_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_desc (push_desc),
      .pop       (pop),
      .empty     (q_empty),
      .head      (q_head)
   );

   ats_back u_back (
      .clock          (clock),
      .reset          (reset),
      .wr             (wr),
      .q_empty        (q_empty),
      .q_head         (q_head),
      .pop            (pop),
      .rel            (rel),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_token_char (rsp_token_char),
      .rsp_token_last (rsp_token_last)
   );

endmodule

// ===== rtl/core/ats_checker.sv =====
// port-level checker for the tokenizer top level and its bind
`timescale 1ns / 1ps
module ats_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic [7:0] req_text_byte,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_token_char,
   input logic       rsp_token_last
);

   // stalled request holds
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_text_byte))
      else $error("stalled request changed");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_token_char) &&
                                 $stable(rsp_token_last))
      else $error("stalled result changed");

   // emitted characters are lower-case letters or digits
   a_rsp_alnum: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_token_char >= 8'h30 && rsp_token_char <= 8'h39) ||
                    (rsp_token_char >= 8'h61 && rsp_token_char <= 8'h7A))
      else $error("result character not lower-case alphanumeric");

   // reset leaves no result pending
   a_reset_out: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // reset frees both banks, so input is open
   a_reset_in: assert property (@(posedge clock)
      reset |=> !req_stall)
      else $error("input stalled right after reset");

endmodule

bind alnum_tokenizer_suffix_stemmer_unit ats_checker u_ats_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .req_text_byte  (req_text_byte),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_token_char (rsp_token_char),
   .rsp_token_last (rsp_token_last)
);
